FILE: rtl/core/rover_drive_command_ramp_assert.svh
// ----------------------------------------------------------------------------
// Rover drive command ramp assertion macros
// Shared property macros for the drive command ramp block.
// ----------------------------------------------------------------------------
`ifndef ROVER_DRIVE_COMMAND_RAMP_ASSERT_SVH
`define ROVER_DRIVE_COMMAND_RAMP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RDCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rdcr: same-cycle property failed");

// Next-cycle implication, checked outside reset.
`define RDCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rdcr: next-cycle property failed");

`endif

FILE: rtl/core/rdcr_pkg.sv
// ----------------------------------------------------------------------------
// Rover drive command ramp package
// Payload types, command letters and fixed duty constants.
// ----------------------------------------------------------------------------
package rdcr_pkg;

  // One control tick as it arrives.
  typedef struct packed {
    logic [3:0] remote_pins;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [9:0] distance_sample;
  } in_item_t;

  // One result per tick.
  typedef struct packed {
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       obstacle_block;
  } out_item_t;

  // Configuration register indexes.
  localparam logic CFG_OBSTACLE_THRESHOLD = 1'b0;
  localparam logic CFG_TURN_DUTY          = 1'b1;
  localparam int unsigned CFG_DATA_W      = 10;

  // Remote line patterns (active low).
  localparam logic [3:0] PINS_FWD  = 4'hE;
  localparam logic [3:0] PINS_BACK = 4'hD;
  localparam logic [3:0] PINS_RGT  = 4'hB;
  localparam logic [3:0] PINS_LFT  = 4'h7;
  localparam logic [3:0] PINS_NONE = 4'hF;

  // Command letters.
  localparam logic [7:0] CMD_NONE      = 8'h00;
  localparam logic [7:0] CMD_FWD       = 8'h41; // A
  localparam logic [7:0] CMD_CURVE_RU  = 8'h42; // B
  localparam logic [7:0] CMD_CURVE_LU  = 8'h43; // C
  localparam logic [7:0] CMD_RIGHT     = 8'h44; // D
  localparam logic [7:0] CMD_CURVE_RD  = 8'h46; // F
  localparam logic [7:0] CMD_CURVE_LD  = 8'h47; // G
  localparam logic [7:0] CMD_ALERT_ON  = 8'h48; // H
  localparam logic [7:0] CMD_BACK      = 8'h49; // I
  localparam logic [7:0] CMD_LIM_J     = 8'h4A; // J
  localparam logic [7:0] CMD_LIM_K     = 8'h4B; // K
  localparam logic [7:0] CMD_ALERT_OFF = 8'h4C; // L
  localparam logic [7:0] CMD_STOP      = 8'h4E; // N
  localparam logic [7:0] CMD_RAMP_P    = 8'h50; // P
  localparam logic [7:0] CMD_RAMP_Q    = 8'h51; // Q
  localparam logic [7:0] CMD_RAMP_R    = 8'h52; // R
  localparam logic [7:0] CMD_LEFT      = 8'h53; // S
  localparam logic [7:0] CMD_RAMP_T    = 8'h54; // T
  localparam logic [7:0] CMD_RAMP_V    = 8'h56; // V
  localparam logic [7:0] CMD_LIM_W     = 8'h57; // W
  localparam logic [7:0] CMD_LIM_Y     = 8'h59; // Y
  localparam logic [7:0] CMD_LIM_Z     = 8'h5A; // Z

  // Duty and speed constants.
  localparam logic [7:0] STOP_DUTY        = 8'd127;
  localparam logic [7:0] CURVE_STEP       = 8'd5;
  localparam logic [7:0] CURVE_HIGH_CLAMP = 8'd230;
  localparam logic [7:0] CURVE_LOW_CLAMP  = 8'd20;
  localparam logic [7:0] DUTY_MAX         = 8'd255;
  localparam logic [7:0] CURVE_TOP        = 8'd250;

  // Reset values.
  localparam logic [9:0] THRESH_RST   = 10'd62;
  localparam logic [7:0] TURN_RST     = 8'd190;
  localparam logic [3:0] RAMP_RST     = 4'd9;
  localparam logic [7:0] FWD_LIM_RST  = 8'd195;
  localparam logic [7:0] REV_LIM_RST  = 8'd50;

endpackage

FILE: rtl/core/rover_drive_command_ramp.sv
// ----------------------------------------------------------------------------
// Rover drive command ramp
// Throughput: one request per cycle while the result side is not stalled; an
// input register feeds one pass of command logic into the result register,
// which also updates the state.
// Reset: asynchronous, active low; speeds and duties go to 127, command clear.
// ----------------------------------------------------------------------------
`include "rover_drive_command_ramp_assert.svh"

module rover_drive_command_ramp
  import rdcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  // Configuration registers.
  logic [9:0] thresh_q;
  logic [7:0] turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      turn_q   <= TURN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBSTACLE_THRESHOLD: thresh_q <= cfg_data_i;
        CFG_TURN_DUTY:          turn_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake control for the input and result registers.
  logic     s1_valid_q;
  in_item_t s1_q;
  logic     out_valid_q;
  out_item_t out_q;
  logic     advance;
  logic     s1_load;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_load    = !s1_valid_q || advance;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_q <= in_item_i;
    end
  end

  // Drive state.
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] last_q, last_d;
  logic       held_q, held_d;
  logic       alert_q, alert_d;
  logic [7:0] sr_q, sr_d;
  logic [7:0] sl_q, sl_d;
  logic [7:0] dl_q, dl_d;
  logic [7:0] dr_q, dr_d;
  logic [3:0] ramp_q, ramp_d;
  logic [7:0] fwd_q, fwd_d;
  logic [7:0] rev_q, rev_d;
  logic       block_c;

  // Command selection: remote, then received byte, then obstacle override.
  always_comb begin
    cmd_d  = cmd_q;
    held_d = held_q;
    last_d = last_q;
    case (s1_q.remote_pins)
      PINS_FWD:  begin cmd_d = CMD_FWD;   held_d = 1'b1; end
      PINS_BACK: begin cmd_d = CMD_BACK;  held_d = 1'b1; end
      PINS_RGT:  begin cmd_d = CMD_RIGHT; held_d = 1'b1; end
      PINS_LFT:  begin cmd_d = CMD_LEFT;  held_d = 1'b1; end
      PINS_NONE: begin
        if (held_q) begin
          cmd_d  = CMD_STOP;
          held_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (s1_q.rx_valid) begin
      cmd_d  = s1_q.rx_byte;
      last_d = s1_q.rx_byte;
    end
    block_c = alert_q && (s1_q.distance_sample <= thresh_q);
    if (block_c) begin
      if (last_d == CMD_BACK) begin
        cmd_d = CMD_BACK;
      end else if (last_d == CMD_ALERT_OFF) begin
        cmd_d = CMD_ALERT_OFF;
      end else begin
        cmd_d = CMD_STOP;
      end
    end
  end

  // Command application to speeds, duties and settings.
  logic [8:0] sum;
  logic [7:0] avg;
  logic [8:0] step9;

  always_comb begin
    sr_d    = sr_q;
    sl_d    = sl_q;
    dl_d    = dl_q;
    dr_d    = dr_q;
    ramp_d  = ramp_q;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    alert_d = alert_q;
    sum     = {1'b0, sr_q} + {1'b0, sl_q};
    avg     = sum[8:1];
    step9   = {5'd0, ramp_q};
    case (cmd_d)
      CMD_FWD: begin
        if (avg < STOP_DUTY) avg = STOP_DUTY;
        if (({1'b0, avg} + step9) > {1'b0, fwd_q}) avg = fwd_q;
        else avg = avg + {4'd0, ramp_q};
        sr_d = avg; sl_d = avg; dl_d = avg; dr_d = avg;
      end
      CMD_STOP: begin
        sr_d = STOP_DUTY; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = STOP_DUTY;
      end
      CMD_BACK: begin
        if (avg > STOP_DUTY) avg = STOP_DUTY;
        if ({1'b0, avg} < ({1'b0, rev_q} + step9)) avg = rev_q;
        else avg = avg - {4'd0, ramp_q};
        sr_d = avg; sl_d = avg; dl_d = avg; dr_d = avg;
      end
      CMD_RIGHT: begin
        sr_d = turn_q; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = turn_q;
      end
      CMD_LEFT: begin
        sr_d = STOP_DUTY; sl_d = turn_q; dl_d = turn_q; dr_d = STOP_DUTY;
      end
      CMD_CURVE_RU: begin
        if (sr_d < STOP_DUTY) begin
          sr_d = STOP_DUTY; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = STOP_DUTY;
        end
        if (sl_d > CURVE_HIGH_CLAMP) sl_d = CURVE_HIGH_CLAMP;
        sr_d = (sr_d > CURVE_TOP) ? DUTY_MAX : sr_d + CURVE_STEP;
        dr_d = sr_d;
      end
      CMD_CURVE_LU: begin
        if (sr_d < STOP_DUTY) begin
          sr_d = STOP_DUTY; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = STOP_DUTY;
        end
        if (sr_d > CURVE_HIGH_CLAMP) sr_d = CURVE_HIGH_CLAMP;
        sl_d = (sl_d > CURVE_TOP) ? DUTY_MAX : sl_d + CURVE_STEP;
        dl_d = sl_d;
      end
      CMD_CURVE_RD: begin
        if (sr_d > STOP_DUTY) begin
          sr_d = STOP_DUTY; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = STOP_DUTY;
        end
        if (sl_d < CURVE_LOW_CLAMP) sl_d = CURVE_LOW_CLAMP;
        sr_d = (sr_d < CURVE_STEP) ? 8'd0 : sr_d - CURVE_STEP;
        dr_d = sr_d;
      end
      CMD_CURVE_LD: begin
        if (sr_d > STOP_DUTY) begin
          sr_d = STOP_DUTY; sl_d = STOP_DUTY; dl_d = STOP_DUTY; dr_d = STOP_DUTY;
        end
        if (sr_d < CURVE_LOW_CLAMP) sr_d = CURVE_LOW_CLAMP;
        sl_d = (sl_d < CURVE_STEP) ? 8'd0 : sl_d - CURVE_STEP;
        dl_d = sl_d;
      end
      CMD_RAMP_P:    ramp_d = 4'd2;
      CMD_RAMP_Q:    ramp_d = 4'd3;
      CMD_RAMP_R:    ramp_d = 4'd4;
      CMD_RAMP_T:    ramp_d = 4'd5;
      CMD_RAMP_V:    ramp_d = 4'd7;
      CMD_LIM_Z:     begin rev_d = 8'd0;   fwd_d = 8'd255; end
      CMD_LIM_J:     begin rev_d = 8'd25;  fwd_d = 8'd220; end
      CMD_LIM_K:     begin rev_d = 8'd50;  fwd_d = 8'd195; end
      CMD_LIM_Y:     begin rev_d = 8'd75;  fwd_d = 8'd170; end
      CMD_LIM_W:     begin rev_d = 8'd100; fwd_d = 8'd145; end
      CMD_ALERT_ON:  alert_d = 1'b1;
      CMD_ALERT_OFF: alert_d = 1'b0;
      default: ;
    endcase
  end

  // State update, one step per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_NONE;
      last_q  <= CMD_NONE;
      held_q  <= 1'b0;
      alert_q <= 1'b0;
      sr_q    <= STOP_DUTY;
      sl_q    <= STOP_DUTY;
      dl_q    <= STOP_DUTY;
      dr_q    <= STOP_DUTY;
      ramp_q  <= RAMP_RST;
      fwd_q   <= FWD_LIM_RST;
      rev_q   <= REV_LIM_RST;
    end else if (advance) begin
      cmd_q   <= cmd_d;
      last_q  <= last_d;
      held_q  <= held_d;
      alert_q <= alert_d;
      sr_q    <= sr_d;
      sl_q    <= sl_d;
      dl_q    <= dl_d;
      dr_q    <= dr_d;
      ramp_q  <= ramp_d;
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.duty_left      <= dl_d;
      out_q.duty_right     <= dr_d;
      out_q.obstacle_block <= block_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the block's own control.
  `RDCR_ASSERT_NXT(a_adv_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `RDCR_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o,
                   s1_valid_q && out_valid_q && out_stall_i)
  `RDCR_ASSERT_NXT(a_fwd_equal, clk_i, rst_ni, advance && (cmd_d == CMD_FWD),
                   sr_q == sl_q)

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Rover drive command ramp testbench
// Drives control ticks through the valid/stall request channel and checks
// every result against a cycle-free predictor of the command, ramp and curve
// logic. Directed tests for the remote lines, curve steps, letter commands
// and the obstacle alert come first. Random traffic follows under several
// threshold and turn duty settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rdcr_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  rover_drive_command_ramp i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Clock with an 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the drive state and configuration.
  logic [9:0] thresh_cfg     = THRESH_RST;
  logic [7:0] turn_cfg       = TURN_RST;
  logic [7:0] cmd_now        = CMD_NONE;
  logic [7:0] last_rx        = CMD_NONE;
  logic       remote_latched = 1'b0;
  logic       alert_on       = 1'b0;
  logic [7:0] spd_r          = STOP_DUTY;
  logic [7:0] spd_l          = STOP_DUTY;
  logic [7:0] duty_l         = STOP_DUTY;
  logic [7:0] duty_r         = STOP_DUTY;
  logic [3:0] ramp_inc       = RAMP_RST;
  logic [7:0] fwd_cap        = FWD_LIM_RST;
  logic [7:0] rev_cap        = REV_LIM_RST;

  out_item_t   expected_duty[$];
  int unsigned idle_max;
  int unsigned n_sent;
  int unsigned n_checked    = 0;
  int unsigned n_cfg;
  int unsigned n_errors     = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  // Both speeds and both duties back to the stop value.
  function automatic void recenter();
    spd_r  = STOP_DUTY;
    spd_l  = STOP_DUTY;
    duty_l = STOP_DUTY;
    duty_r = STOP_DUTY;
  endfunction

  // One control tick of the drive logic; returns the duties it leaves.
  function automatic out_item_t drive_tick(input in_item_t it);
    out_item_t res;
    int        avg;
    logic      blocked;
    blocked = 1'b0;

    // Remote lines are active low; only single presses and release count.
    case (it.remote_pins)
      PINS_FWD: begin
        cmd_now = CMD_FWD;
        remote_latched = 1'b1;
      end
      PINS_BACK: begin
        cmd_now = CMD_BACK;
        remote_latched = 1'b1;
      end
      PINS_RGT: begin
        cmd_now = CMD_RIGHT;
        remote_latched = 1'b1;
      end
      PINS_LFT: begin
        cmd_now = CMD_LEFT;
        remote_latched = 1'b1;
      end
      PINS_NONE: begin
        if (remote_latched) begin
          cmd_now = CMD_STOP;
          remote_latched = 1'b0;
        end
      end
      default: ;
    endcase

    // A received byte wins over the remote.
    if (it.rx_valid) begin
      cmd_now = it.rx_byte;
      last_rx = it.rx_byte;
    end

    // A close obstacle forces stop unless the last byte was back or alert off.
    if (alert_on && (it.distance_sample <= thresh_cfg)) begin
      blocked = 1'b1;
      cmd_now = CMD_STOP;
      if (last_rx == CMD_BACK) cmd_now = CMD_BACK;
      if (last_rx == CMD_ALERT_OFF) cmd_now = CMD_ALERT_OFF;
    end

    // Apply the command that is in force.
    case (cmd_now)
      CMD_FWD: begin
        avg = (int'(spd_r) + int'(spd_l)) / 2;
        if (avg < int'(STOP_DUTY)) avg = int'(STOP_DUTY);
        if (avg + int'(ramp_inc) > int'(fwd_cap)) avg = int'(fwd_cap);
        else avg = avg + int'(ramp_inc);
        spd_r  = avg[7:0];
        spd_l  = avg[7:0];
        duty_l = spd_l;
        duty_r = spd_r;
      end
      CMD_STOP: recenter();
      CMD_BACK: begin
        avg = (int'(spd_r) + int'(spd_l)) / 2;
        if (avg > int'(STOP_DUTY)) avg = int'(STOP_DUTY);
        if (avg < int'(rev_cap) + int'(ramp_inc)) avg = int'(rev_cap);
        else avg = avg - int'(ramp_inc);
        spd_r  = avg[7:0];
        spd_l  = avg[7:0];
        duty_l = spd_l;
        duty_r = spd_r;
      end
      CMD_RIGHT: begin
        spd_r  = turn_cfg;
        spd_l  = STOP_DUTY;
        duty_l = spd_l;
        duty_r = spd_r;
      end
      CMD_LEFT: begin
        spd_r  = STOP_DUTY;
        spd_l  = turn_cfg;
        duty_l = spd_l;
        duty_r = spd_r;
      end
      CMD_CURVE_RU: begin
        if (spd_r < STOP_DUTY) recenter();
        if (spd_l > CURVE_HIGH_CLAMP) spd_l = CURVE_HIGH_CLAMP;
        spd_r  = (spd_r > CURVE_TOP) ? DUTY_MAX : spd_r + CURVE_STEP;
        duty_r = spd_r;
      end
      CMD_CURVE_LU: begin
        if (spd_r < STOP_DUTY) recenter();
        if (spd_r > CURVE_HIGH_CLAMP) spd_r = CURVE_HIGH_CLAMP;
        spd_l  = (spd_l > CURVE_TOP) ? DUTY_MAX : spd_l + CURVE_STEP;
        duty_l = spd_l;
      end
      CMD_CURVE_RD: begin
        if (spd_r > STOP_DUTY) recenter();
        if (spd_l < CURVE_LOW_CLAMP) spd_l = CURVE_LOW_CLAMP;
        spd_r  = (spd_r < CURVE_STEP) ? 8'd0 : spd_r - CURVE_STEP;
        duty_r = spd_r;
      end
      CMD_CURVE_LD: begin
        if (spd_r > STOP_DUTY) recenter();
        if (spd_r < CURVE_LOW_CLAMP) spd_r = CURVE_LOW_CLAMP;
        spd_l  = (spd_l < CURVE_STEP) ? 8'd0 : spd_l - CURVE_STEP;
        duty_l = spd_l;
      end
      CMD_RAMP_P: ramp_inc = 4'd2;
      CMD_RAMP_Q: ramp_inc = 4'd3;
      CMD_RAMP_R: ramp_inc = 4'd4;
      CMD_RAMP_T: ramp_inc = 4'd5;
      CMD_RAMP_V: ramp_inc = 4'd7;
      CMD_LIM_Z: begin
        rev_cap = 8'd0;
        fwd_cap = 8'd255;
      end
      CMD_LIM_J: begin
        rev_cap = 8'd25;
        fwd_cap = 8'd220;
      end
      CMD_LIM_K: begin
        rev_cap = 8'd50;
        fwd_cap = 8'd195;
      end
      CMD_LIM_Y: begin
        rev_cap = 8'd75;
        fwd_cap = 8'd170;
      end
      CMD_LIM_W: begin
        rev_cap = 8'd100;
        fwd_cap = 8'd145;
      end
      CMD_ALERT_ON:  alert_on = 1'b1;
      CMD_ALERT_OFF: alert_on = 1'b0;
      default: ;
    endcase

    res.duty_left      = duty_l;
    res.duty_right     = duty_r;
    res.obstacle_block = blocked;
    return res;
  endfunction

  function automatic in_item_t make_tick(input logic [3:0] pins, input logic rxv,
                                         input logic [7:0] rx, input logic [9:0] smp);
    in_item_t it;
    it.remote_pins     = pins;
    it.rx_valid        = rxv;
    it.rx_byte         = rx;
    it.distance_sample = smp;
    return it;
  endfunction

  // Send one request after a random gap and record its expected duties.
  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_duty.push_back(drive_tick(it));
    n_sent++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_duty.size() != 0);
  endtask

  // Write one configuration register while the block is idle.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_OBSTACLE_THRESHOLD) thresh_cfg = data;
    else turn_cfg = data[7:0];
    n_cfg++;
  endtask

  // Turn duty with random unused upper bits.
  task automatic write_turn(input logic [7:0] duty);
    logic [CFG_DATA_W-1:0] word;
    word      = 10'($urandom_range(0, 1023));
    word[7:0] = duty;
    write_reg(CFG_TURN_DUTY, word);
  endtask

  function automatic logic [7:0] pick_letter(input int unsigned k);
    case (k)
      0:  return CMD_FWD;
      1:  return CMD_CURVE_RU;
      2:  return CMD_CURVE_LU;
      3:  return CMD_RIGHT;
      4:  return CMD_CURVE_RD;
      5:  return CMD_CURVE_LD;
      6:  return CMD_ALERT_ON;
      7:  return CMD_BACK;
      8:  return CMD_LIM_J;
      9:  return CMD_LIM_K;
      10: return CMD_ALERT_OFF;
      11: return CMD_STOP;
      12: return CMD_RAMP_P;
      13: return CMD_RAMP_Q;
      14: return CMD_RAMP_R;
      15: return CMD_LEFT;
      16: return CMD_RAMP_T;
      17: return CMD_RAMP_V;
      18: return CMD_LIM_W;
      19: return CMD_LIM_Y;
      default: return CMD_LIM_Z;
    endcase
  endfunction

  // Distance sample, mostly clear of the threshold and now and then close.
  function automatic logic [9:0] pick_distance();
    if (($urandom_range(0, 7) == 0) || (thresh_cfg == 10'd1023))
      return 10'($urandom_range(0, int'(thresh_cfg)));
    return 10'($urandom_range(int'(thresh_cfg) + 1, 1023));
  endfunction

  // Tick with no byte and the remote released.
  function automatic in_item_t quiet_tick();
    return make_tick(PINS_NONE, 1'b0, 8'($urandom_range(0, 255)), pick_distance());
  endfunction

  // Each single remote line, release, and a multi-line pattern that is ignored.
  task automatic test_remote_lines();
    idle_max = 3;
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_FWD, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_FWD, 1'b0, CMD_NONE, 10'd0));
    send_tick(make_tick(4'h0, 1'b0, 8'hFF, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd512));
    send_tick(make_tick(PINS_BACK, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_RGT, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_LFT, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd1023));
  endtask

  // Curve steps on one side, repeated command and the recentering clamp.
  task automatic test_curve_commands();
    idle_max = 0;
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_CURVE_RU, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_CURVE_RD, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_CURVE_LU, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_CURVE_LD, 10'd1023));
  endtask

  // Limit and ramp letters leave duties alone; unknown bytes change nothing.
  task automatic test_letter_commands();
    idle_max = 3;
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_LIM_Z, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_RAMP_P, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, 8'hFF, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_NONE, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_FWD, 10'd1023));
  endtask

  // Alert override at both threshold extremes, with back and alert-off escapes.
  task automatic test_obstacle_alert();
    write_reg(CFG_OBSTACLE_THRESHOLD, 10'd1023);
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_ALERT_ON, 10'd1023));
    send_tick(make_tick(PINS_FWD, 1'b0, CMD_NONE, 10'd512));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_BACK, 10'd0));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_ALERT_OFF, 10'd1023));
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd0));
    write_reg(CFG_OBSTACLE_THRESHOLD, 10'd0);
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_ALERT_ON, 10'd0));
    send_tick(make_tick(PINS_NONE, 1'b1, CMD_FWD, 10'd1));
    send_tick(make_tick(PINS_NONE, 1'b0, CMD_NONE, 10'd0));
  endtask

  // Command sequences with held ticks, remote presses and raw noise.
  task automatic random_burst(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned hold;
    logic [3:0]  pins;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      idle_max = ($urandom_range(0, 4) == 0) ? 0 : 3;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        pins = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : PINS_NONE;
        send_tick(make_tick(pins, 1'b1, pick_letter($urandom_range(0, 20)),
                            pick_distance()));
        hold = $urandom_range(0, 30);
        repeat (hold) send_tick(quiet_tick());
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0:       pins = PINS_FWD;
          1:       pins = PINS_BACK;
          2:       pins = PINS_RGT;
          default: pins = PINS_LFT;
        endcase
        hold = $urandom_range(1, 12);
        repeat (hold) send_tick(make_tick(pins, 1'b0, 8'($urandom_range(0, 255)),
                                          pick_distance()));
        send_tick(quiet_tick());
      end else if (kind < 90) begin
        send_tick(make_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023))));
      end else begin
        send_tick(make_tick(PINS_NONE, 1'b1, 8'($urandom_range(0, 255)),
                            pick_distance()));
      end
    end
  endtask

  // Random traffic under default, minimum, maximum and random settings.
  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_OBSTACLE_THRESHOLD, THRESH_RST);
          write_turn(TURN_RST);
        end
        1: begin
          write_reg(CFG_OBSTACLE_THRESHOLD, 10'd0);
          write_turn(8'd0);
        end
        2: begin
          write_reg(CFG_OBSTACLE_THRESHOLD, 10'd1023);
          write_turn(8'd255);
        end
        default: begin
          write_reg(CFG_OBSTACLE_THRESHOLD, 10'($urandom_range(0, 200)));
          write_turn(8'($urandom_range(0, 255)));
        end
      endcase
      random_burst(72);
    end
  endtask

  // Result side: random stalls and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_duty.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: L=%0d R=%0d blk=%0d", out_item_o.duty_left,
                     out_item_o.duty_right, out_item_o.obstacle_block);
        end else begin
          want = expected_duty.pop_front();
          n_checked++;
          if ((out_item_o.duty_left !== want.duty_left) ||
              (out_item_o.duty_right !== want.duty_right) ||
              (out_item_o.obstacle_block !== want.obstacle_block)) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch on result %0d: expected L=%0d R=%0d blk=%0d, got L=%0d R=%0d blk=%0d",
                       n_checked, want.duty_left, want.duty_right, want.obstacle_block,
                       out_item_o.duty_left, out_item_o.duty_right,
                       out_item_o.obstacle_block);
          end
        end
        stall_left = $urandom_range(0, idle_max);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("watchdog: no progress for %0d cycles", quiet_cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_OBSTACLE_THRESHOLD;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    in_item_i    <= '0;
    idle_max     = 3;
    n_sent       = 0;
    n_cfg        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_remote_lines();
    test_curve_commands();
    test_letter_commands();
    test_obstacle_alert();
    test_random_traffic();

    settle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d ticks covering remote lines, curves, ramps, limits and alerts.",
             n_sent);
    $display("Checked %0d results across %0d register writes.", n_checked, n_cfg);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rdcr_pkg.sv
rtl/core/rover_drive_command_ramp.sv
dv/testbench.sv
